[rtl/krt_pkg.sv]
// ============================================================================
// Keyed record table package
// Shared types, codes and sizes for the record table and its record memory.
// ============================================================================
package krt_pkg;

    // Table geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths on the stream ports.
    localparam int KEY_W     = 32;
    localparam int QTY_W     = 32;
    localparam int PRICE_W   = 32;
    localparam int INDEX_W   = 6;
    localparam int OPCODE_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    // Stream packing: key, quantity, price, index on the input side;
    // key, quantity, price, count on the output side; padded to bytes.
    localparam int IN_FIELDS_W  = KEY_W + QTY_W + PRICE_W + INDEX_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = KEY_W + QTY_W + PRICE_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    // One stored record, key in the low bits.
    typedef struct packed {
        logic [PRICE_W-1:0]       price;
        logic signed [QTY_W-1:0]  qty;
        logic signed [KEY_W-1:0]  key;
    } rec_t;

    // Access request from the sequencer to the record memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        rec_t              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

[rtl/keyed_record_table_top.sv]
// ============================================================================
// Keyed record table, top level
// A packed table of records (key, quantity, price) held in one synchronous
// memory, with insert, lookup, update, delete-with-compaction and indexed read.
// ============================================================================
//
// Channel   Direction  Handshake          Beat contents
// -------   ---------  -----------------  ------------------------------------
// s_*       in         s_tvalid/s_tready  tuser: opcode; tdata: request record
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: result record
//
// Requests are handled one at a time, and every request gives exactly one
// result beat. Insert, unused opcodes and every request refused up front go
// straight from idle to the response state; a read by index passes through
// the read-data state first; lookup, update and delete scan the entries from
// slot 0 up to the first match, or through all entries of the table when
// nothing matches. Delete then moves every entry above the match down one
// slot. The single read port of the record memory is why the scan and the
// compaction touch one entry a cycle. Reset clears the state machine, the
// entry count and the output valid; the record memory is not cleared, since
// only slots below the count are ever read. A stalled result waits in the
// output register while the next request is accepted and processed; it is
// replaced only once it has been taken.
// ============================================================================
module keyed_record_table_top
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // From bit 0: key[31:0], quantity_in[63:32], price_in[95:64],
    // entry_index[101:96], zero pad.
    input  logic [krt_pkg::IN_DATA_W-1:0]  s_tdata,
    // From bit 0: opcode[2:0].
    input  logic [krt_pkg::OPCODE_W-1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // From bit 0: key_out[31:0], quantity_out[63:32], price_out[95:64],
    // entry_count[102:96], zero pad.
    output logic [krt_pkg::OUT_DATA_W-1:0] m_tdata,
    // From bit 0: status[1:0].
    output logic [krt_pkg::STATUS_W-1:0]   m_tuser
);
    import krt_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,  // waiting for a request
        ST_SCAN  = 5'b00010,  // comparing one entry per cycle against the key
        ST_SHIFT = 5'b00100,  // moving entries above a deleted one down a slot
        ST_RDATA = 5'b01000,  // capturing the entry of a read by index
        ST_RESP  = 5'b10000   // handing the result to the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    opcode_t             op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [QTY_W-1:0]    qty_reg, qty_next;
    // Address of the read whose data arrives this cycle (scan and shift).
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    status_t             res_status_reg, res_status_next;
    rec_t                res_rec_reg, res_rec_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    ram_req_t            ram_req;
    rec_t                rd_data;

    // Request fields as they arrive.
    logic                accept;
    opcode_t             in_op;
    rec_t                in_rec;
    logic [INDEX_W-1:0]  in_index;
    logic [CNT_W-1:0]    addr_plus1;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = opcode_t'(s_tuser);
    assign in_rec.key   = s_tdata[KEY_W-1:0];
    assign in_rec.qty   = s_tdata[KEY_W+QTY_W-1:KEY_W];
    assign in_rec.price = s_tdata[KEY_W+QTY_W+PRICE_W-1:KEY_W+QTY_W];
    assign in_index     = s_tdata[IN_FIELDS_W-1:KEY_W+QTY_W+PRICE_W];
    assign addr_plus1   = CNT_W'(addr_reg) + CNT_W'(1);

    krt_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        qty_next        = qty_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        ram_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    key_next        = in_rec.key;
                    qty_next        = in_rec.qty;
                    addr_next       = '0;
                    res_status_next = STAT_OK;
                    res_rec_next    = '0;
                    state_next      = ST_RESP;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                // Append at the end; the result echoes the record.
                                ram_req.we    = 1'b1;
                                ram_req.waddr = count_reg[ADDR_W-1:0];
                                ram_req.wdata = in_rec;
                                count_next    = count_reg + CNT_W'(1);
                                res_rec_next  = in_rec;
                            end
                        end
                        OP_LOOKUP, OP_UPDATE, OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(in_index) >= count_reg)
                            begin
                                res_status_next = STAT_BAD_INDEX;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ADDR_W'(in_index);
                                state_next    = ST_RDATA;
                            end
                        end
                        default:
                        begin
                            // Unused opcodes leave the table alone.
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (rd_data.key == key_reg)
                begin
                    res_rec_next = rd_data;
                    state_next   = ST_RESP;
                    if (op_reg == OP_UPDATE)
                    begin
                        ram_req.we        = 1'b1;
                        ram_req.waddr     = addr_reg;
                        ram_req.wdata     = rd_data;
                        ram_req.wdata.qty = qty_reg;
                        res_rec_next.qty  = qty_reg;
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        if (addr_plus1 < count_reg)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = addr_plus1[ADDR_W-1:0];
                            addr_next     = addr_plus1[ADDR_W-1:0];
                            state_next    = ST_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                else if (addr_plus1 < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = addr_plus1[ADDR_W-1:0];
                    addr_next     = addr_plus1[ADDR_W-1:0];
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = ST_RESP;
                end
            end

            ST_SHIFT:
            begin
                // The entry just read moves one slot down; the next read and
                // this write never address the same slot.
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_reg - ADDR_W'(1);
                ram_req.wdata = rd_data;
                if (addr_plus1 < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = addr_plus1[ADDR_W-1:0];
                    addr_next     = addr_plus1[ADDR_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end
            end

            ST_RDATA:
            begin
                res_rec_next = rd_data;
                state_next   = ST_RESP;
            end

            ST_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded from the result when it is free or being taken.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_RESP) && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
            m_user_next  = res_status_reg;
            m_data_next  = {{OUT_PAD_W{1'b0}}, COUNT_W'(count_reg),
                            res_rec_reg.price, res_rec_reg.qty, res_rec_reg.key};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        qty_reg        <= qty_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        m_user_reg     <= m_user_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // An accepted insert into a table with room grows the count by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_INSERT) && (count_reg < CNT_W'(DEPTH)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the entry count");

    // Compaction only runs on a table with at least two entries, and only
    // reads slots below the count.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> ((count_reg >= CNT_W'(2))
                                     && (CNT_W'(addr_reg) < count_reg)))
        else $error("compaction outside the valid entries");

    // A new result beat only ever comes from the response state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result loaded outside the response state");

endmodule

[rtl/krt_ram.sv]
// ============================================================================
// Keyed record table memory
// Record store with one write port and one read port; read data is
// registered, so it appears in the cycle after the read is issued.
// ============================================================================
module krt_ram
(
    input  logic              clk,
    input  krt_pkg::ram_req_t req,
    output krt_pkg::rec_t     rd_data
);
    import krt_pkg::*;

    rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule
